// ===== rtl/slpb_pkg.sv =====
// Shared types, register codes and reset values for the serial-to-parallel link bridge.
// No dependencies; every other file of the bridge imports this package.
`timescale 1ns / 1ps
`default_nettype none

package slpb_pkg;

  // Depth of the sample queue between front and back
  localparam int SLPB_QUEUE_DEPTH = 2;

  // Configuration port geometry: eight byte registers at 4*i
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // Device state that reports a transfer error
  localparam logic [7:0] TRANSFER_ERROR_STATE = 8'd2;

  // Register reset values
  localparam logic [7:0] RST_OWN_ADDRESS   = 8'd57;
  localparam logic [7:0] RST_ATTENTION     = 8'd217;
  localparam logic [7:0] RST_READY         = 8'd237;
  localparam logic [7:0] RST_BUSY          = 8'd253;
  localparam logic [7:0] RST_END_TRANSFER  = 8'd114;
  localparam logic [7:0] RST_END_RECEIVE   = 8'd174;
  localparam logic [7:0] RST_REPEAT        = 8'd154;
  localparam logic [7:0] RST_WORK_DONE     = 8'd1;

  // Register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_OWN_ADDRESS  = 3'd0,
    REG_ATTENTION    = 3'd1,
    REG_READY        = 3'd2,
    REG_BUSY         = 3'd3,
    REG_END_TRANSFER = 3'd4,
    REG_END_RECEIVE  = 3'd5,
    REG_REPEAT       = 3'd6,
    REG_WORK_DONE    = 3'd7
  } reg_idx_t;

  // Protocol phases
  typedef enum logic [2:0] {
    PH_ADDR   = 3'd0,
    PH_REQ    = 3'd1,
    PH_READ   = 3'd2,
    PH_REPLY  = 3'd3,
    PH_RELAY  = 3'd4,
    PH_REQ2   = 3'd5,
    PH_READ2  = 3'd6,
    PH_FINAL  = 3'd7
  } phase_t;

  // Register file contents
  typedef struct packed {
    logic [7:0] own_address;
    logic [7:0] attention_code;
    logic [7:0] ready_code;
    logic [7:0] busy_code;
    logic [7:0] end_transfer_code;
    logic [7:0] end_receive_code;
    logic [7:0] repeat_code;
    logic [7:0] work_done_state;
  } cfg_t;

  // One classified pin sample
  typedef struct packed {
    logic       c1;
    logic       c2;
    logic       din;
    logic [7:0] dev;
    logic       dev_free;
    logic       dev_err;
  } sample_t;

endpackage

`default_nettype wire

// ===== rtl/serial_to_parallel_link_bridge.sv =====
// Channel   Handshake           Payload
// input     in_valid/in_ready   in_c1_level, in_c2_level, in_serial_in, in_device_byte
// result    out_valid/out_ready out_serial_out, out_serial_drive, out_parallel_out,
//                               out_parallel_drive, out_phase
// config    psel/penable/pready paddr, pwrite, pwdata, prdata (APB-style, byte regs at 4*i)
//
// One pin sample request is taken every cycle while in_ready is high; each gives one result,
// passing the front register, the sample queue and the result register of the protocol engine.
// The protocol engine in the back stage updates once per sample and sets that rate.
// Synchronous active-low reset clears all control state; no clearing pass.
// A stalled result holds in the result register; the queue absorbs samples and
// in_ready falls once the front register and queue are both full.
`timescale 1ns / 1ps
`default_nettype none

module serial_to_parallel_link_bridge #(
  parameter int QUEUE_DEPTH = slpb_pkg::SLPB_QUEUE_DEPTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            in_c1_level,
  input  wire logic                            in_c2_level,
  input  wire logic                            in_serial_in,
  input  wire logic [7:0]                      in_device_byte,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 out_serial_out,
  output logic                                 out_serial_drive,
  output logic [7:0]                           out_parallel_out,
  output logic                                 out_parallel_drive,
  output logic [2:0]                           out_phase,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [slpb_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [slpb_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [slpb_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                 pready
);
  import slpb_pkg::*;

  cfg_t    cfg;
  sample_t f_sample, q_sample;
  logic    f_push, q_ready, q_valid, q_pop;

  // Register file
  slpb_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Take and classify sample requests
  slpb_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_c1_level     (in_c1_level),
    .in_c2_level     (in_c2_level),
    .in_serial_in    (in_serial_in),
    .in_device_byte  (in_device_byte),
    .work_done_state (cfg.work_done_state),
    .push_o          (f_push),
    .sample_o        (f_sample),
    .q_ready_i       (q_ready)
  );

  // Decouple front and back
  slpb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (f_push),
    .data_i  (f_sample),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .data_o  (q_sample),
    .pop_i   (q_pop)
  );

  // Protocol engine and result register
  slpb_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_i              (cfg),
    .q_valid_i          (q_valid),
    .q_data_i           (q_sample),
    .pop_o              (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_serial_out     (out_serial_out),
    .out_serial_drive   (out_serial_drive),
    .out_parallel_out   (out_parallel_out),
    .out_parallel_drive (out_parallel_drive),
    .out_phase          (out_phase)
  );

endmodule

`default_nettype wire

// ===== rtl/slpb_cfg.sv =====
// APB-style register file holding the bridge codes.
// Depends on slpb_pkg for the register indexes, reset values and cfg_t.
`timescale 1ns / 1ps
`default_nettype none

module slpb_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [slpb_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [slpb_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [slpb_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                pready,
  output slpb_pkg::cfg_t                      cfg_o
);
  import slpb_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;
  logic [7:0] rd_byte;

  assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg_o  = cfg_r;

  // Decode a write request into the addressed register
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_OWN_ADDRESS:  cfg_nxt.own_address       = pwdata[7:0];
        REG_ATTENTION:    cfg_nxt.attention_code    = pwdata[7:0];
        REG_READY:        cfg_nxt.ready_code        = pwdata[7:0];
        REG_BUSY:         cfg_nxt.busy_code         = pwdata[7:0];
        REG_END_TRANSFER: cfg_nxt.end_transfer_code = pwdata[7:0];
        REG_END_RECEIVE:  cfg_nxt.end_receive_code  = pwdata[7:0];
        REG_REPEAT:       cfg_nxt.repeat_code       = pwdata[7:0];
        REG_WORK_DONE:    cfg_nxt.work_done_state   = pwdata[7:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  // Return the addressed register on a read request
  always_comb begin
    case (idx)
      REG_OWN_ADDRESS:  rd_byte = cfg_r.own_address;
      REG_ATTENTION:    rd_byte = cfg_r.attention_code;
      REG_READY:        rd_byte = cfg_r.ready_code;
      REG_BUSY:         rd_byte = cfg_r.busy_code;
      REG_END_TRANSFER: rd_byte = cfg_r.end_transfer_code;
      REG_END_RECEIVE:  rd_byte = cfg_r.end_receive_code;
      REG_REPEAT:       rd_byte = cfg_r.repeat_code;
      REG_WORK_DONE:    rd_byte = cfg_r.work_done_state;
      default:          rd_byte = 8'd0;
    endcase
  end

  assign prdata = {{(CFG_DATA_W-8){1'b0}}, rd_byte};

  // Hold the registers, load reset values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_address       <= RST_OWN_ADDRESS;
      cfg_r.attention_code    <= RST_ATTENTION;
      cfg_r.ready_code        <= RST_READY;
      cfg_r.busy_code         <= RST_BUSY;
      cfg_r.end_transfer_code <= RST_END_TRANSFER;
      cfg_r.end_receive_code  <= RST_END_RECEIVE;
      cfg_r.repeat_code       <= RST_REPEAT;
      cfg_r.work_done_state   <= RST_WORK_DONE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/slpb_front.sv =====
// Front stage: takes pin sample requests and classifies the device byte.
// Depends on slpb_pkg for sample_t and the transfer error state.
`timescale 1ns / 1ps
`default_nettype none

module slpb_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_c1_level,
  input  wire logic              in_c2_level,
  input  wire logic              in_serial_in,
  input  wire logic [7:0]        in_device_byte,
  input  wire logic [7:0]        work_done_state,
  output logic                   push_o,
  output slpb_pkg::sample_t      sample_o,
  input  wire logic              q_ready_i
);
  import slpb_pkg::*;

  logic    valid_r, valid_nxt;
  sample_t sample_r, sample_nxt;
  logic    in_acc;

  assign in_ready = !valid_r || q_ready_i;
  assign in_acc   = in_valid && in_ready;
  assign push_o   = valid_r && q_ready_i;
  assign sample_o = sample_r;

  // Classify the sample against the device state codes
  always_comb begin
    sample_nxt.c1       = in_c1_level;
    sample_nxt.c2       = in_c2_level;
    sample_nxt.din      = in_serial_in;
    sample_nxt.dev      = in_device_byte;
    sample_nxt.dev_free = (in_device_byte == work_done_state);
    sample_nxt.dev_err  = (in_device_byte == TRANSFER_ERROR_STATE);
  end

  // Load a new request, drop the held one once the queue takes it
  always_comb begin
    if (in_acc) begin
      valid_nxt = 1'b1;
    end else if (push_o) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      sample_r <= sample_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/slpb_queue.sv =====
// Short FIFO of classified samples between the front and back stages.
// Depends on slpb_pkg for sample_t.
`timescale 1ns / 1ps
`default_nettype none

module slpb_queue #(
  parameter int DEPTH = slpb_pkg::SLPB_QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push_i,
  input  slpb_pkg::sample_t      data_i,
  output logic                   ready_o,
  output logic                   valid_o,
  output slpb_pkg::sample_t      data_o,
  input  wire logic              pop_i
);
  import slpb_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  sample_t          mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign ready_o = (cnt_r != FULL_CNT);
  assign valid_o = (cnt_r != '0);
  assign data_o  = mem_r[rd_ptr_r];

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_i) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the pushed sample
  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= data_i;
    end
  end

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> (cnt_r != '0))
    else $error("queue popped while empty");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> (cnt_r != FULL_CNT))
    else $error("queue pushed while full");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    ((cnt_r == '0) || (cnt_r == FULL_CNT)) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with count");
`endif

endmodule

`default_nettype wire

// ===== rtl/slpb_back.sv =====
// Back stage: runs the bus protocol over queued samples and registers one result per sample.
// Depends on slpb_pkg for phase_t, cfg_t, sample_t.
`timescale 1ns / 1ps
`default_nettype none

module slpb_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  slpb_pkg::cfg_t         cfg_i,
  input  wire logic              q_valid_i,
  input  slpb_pkg::sample_t      q_data_i,
  output logic                   pop_o,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_serial_out,
  output logic                   out_serial_drive,
  output logic [7:0]             out_parallel_out,
  output logic                   out_parallel_drive,
  output logic [2:0]             out_phase
);
  import slpb_pkg::*;

  // Protocol state
  phase_t     phase_r, phase_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       frame_r, frame_nxt;
  logic       rel_r, rel_nxt;
  logic       attn_r, attn_nxt;
  logic [7:0] dev_r, dev_nxt;
  logic [7:0] plat_r, plat_nxt;
  logic       slatch_r, slatch_nxt;
  logic [7:0] reply_r, reply_nxt;

  // Result register
  logic       ovalid_r, ovalid_nxt;
  logic       osout_r, osdrv_r, opdrv_r;
  logic [7:0] opout_r;
  logic [2:0] ophase_r;
  logic       sdrive, pdrive;

  // Sample decode
  logic       frame_on, bit_edge, byte_done, pulse_end;
  logic [7:0] byte_upd;
  logic       serial_ph;

  assign pop_o = q_valid_i && (!ovalid_r || out_ready);

  // Decode the sample against the frame state
  always_comb begin
    frame_on  = frame_r | q_data_i.c1;
    bit_edge  = frame_on & q_data_i.c2 & rel_r;
    byte_done = bit_edge & (cnt_r == 3'd7);
    pulse_end = frame_r & !q_data_i.c1;
    byte_upd  = shift_r;
    byte_upd[cnt_r] = q_data_i.din;
    serial_ph = phase_r inside {PH_ADDR, PH_REPLY, PH_RELAY, PH_FINAL};
  end

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_ADDR: begin
        if (byte_done && attn_r && (byte_upd == cfg_i.own_address)) phase_nxt = PH_REQ;
      end
      PH_REQ: begin
        if (pulse_end) phase_nxt = PH_READ;
      end
      PH_READ: begin
        if (pulse_end) phase_nxt = PH_REPLY;
      end
      PH_REPLY: begin
        if (byte_done) begin
          phase_nxt = (dev_r == cfg_i.work_done_state) ? PH_RELAY : PH_ADDR;
        end
      end
      PH_RELAY: begin
        if (byte_done && (byte_upd == cfg_i.end_transfer_code)) phase_nxt = PH_REQ2;
      end
      PH_REQ2: begin
        if (pulse_end) phase_nxt = PH_READ2;
      end
      PH_READ2: begin
        if (pulse_end) phase_nxt = PH_FINAL;
      end
      PH_FINAL: begin
        if (byte_done) phase_nxt = PH_ADDR;
      end
      default: phase_nxt = PH_ADDR;
    endcase
  end

  // Frame, latch and reply updates
  always_comb begin
    shift_nxt  = shift_r;
    cnt_nxt    = cnt_r;
    frame_nxt  = frame_r;
    rel_nxt    = rel_r;
    attn_nxt   = attn_r;
    dev_nxt    = dev_r;
    plat_nxt   = plat_r;
    slatch_nxt = slatch_r;
    reply_nxt  = reply_r;

    if (serial_ph) begin
      // Clock bits on released rising edges of C2
      if (frame_on) begin
        frame_nxt = !byte_done;
        cnt_nxt   = bit_edge ? cnt_r + 1'b1 : cnt_r;
        if (byte_done) begin
          rel_nxt = 1'b1;
        end else if (bit_edge) begin
          rel_nxt = 1'b0;
        end else begin
          rel_nxt = rel_r | !q_data_i.c2;
        end
      end
      case (phase_r)
        PH_ADDR: begin
          if (bit_edge) shift_nxt = byte_upd;
          if (byte_done) attn_nxt = (byte_upd == cfg_i.attention_code);
        end
        PH_RELAY: begin
          if (bit_edge) shift_nxt = byte_upd;
          if (byte_done) plat_nxt = byte_upd;
        end
        default: begin
          if (bit_edge) slatch_nxt = reply_r[cnt_r];
        end
      endcase
    end else begin
      // C1 pulse phases: drive ready or sample the device
      frame_nxt = frame_on;
      case (phase_r)
        PH_REQ, PH_REQ2: begin
          if (frame_on) plat_nxt = cfg_i.ready_code;
        end
        PH_READ: begin
          if (frame_on) dev_nxt = q_data_i.dev;
          if (pulse_end) begin
            reply_nxt = q_data_i.dev_free ? cfg_i.ready_code : cfg_i.busy_code;
          end
        end
        default: begin
          if (frame_on) dev_nxt = q_data_i.dev;
          if (pulse_end) begin
            reply_nxt = q_data_i.dev_err ? cfg_i.repeat_code : cfg_i.end_receive_code;
          end
        end
      endcase
    end

    // Clear phase flags on every change of phase
    if (phase_nxt != phase_r) begin
      frame_nxt = 1'b0;
      cnt_nxt   = 3'd0;
      rel_nxt   = 1'b1;
      if (phase_r == PH_ADDR) attn_nxt = 1'b0;
    end
  end

  // Line drives in the phase just entered
  always_comb begin
    sdrive = phase_nxt inside {PH_REPLY, PH_FINAL};
    pdrive = phase_nxt inside {PH_REQ, PH_RELAY, PH_REQ2};
    ovalid_nxt = pop_o | (ovalid_r & !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_ADDR;
      shift_r  <= 8'd0;
      cnt_r    <= 3'd0;
      frame_r  <= 1'b0;
      rel_r    <= 1'b1;
      attn_r   <= 1'b0;
      dev_r    <= 8'd0;
      plat_r   <= 8'd0;
      slatch_r <= 1'b0;
      reply_r  <= 8'd0;
      ovalid_r <= 1'b0;
    end else begin
      ovalid_r <= ovalid_nxt;
      if (pop_o) begin
        phase_r  <= phase_nxt;
        shift_r  <= shift_nxt;
        cnt_r    <= cnt_nxt;
        frame_r  <= frame_nxt;
        rel_r    <= rel_nxt;
        attn_r   <= attn_nxt;
        dev_r    <= dev_nxt;
        plat_r   <= plat_nxt;
        slatch_r <= slatch_nxt;
        reply_r  <= reply_nxt;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (pop_o) begin
      osout_r  <= sdrive & slatch_nxt;
      osdrv_r  <= sdrive;
      opout_r  <= pdrive ? plat_nxt : 8'd0;
      opdrv_r  <= pdrive;
      ophase_r <= phase_nxt;
    end
  end

  assign out_valid          = ovalid_r;
  assign out_serial_out     = osout_r;
  assign out_serial_drive   = osdrv_r;
  assign out_parallel_out   = opout_r;
  assign out_parallel_drive = opdrv_r;
  assign out_phase          = ophase_r;

`ifndef SYNTHESIS
  a_cnt_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != 3'd0) |-> frame_r)
    else $error("bit count set outside a frame");

  a_pulse_no_bits: assert property (@(posedge clk) disable iff (!rst_n)
    ((phase_r == PH_REQ) || (phase_r == PH_READ) || (phase_r == PH_REQ2) ||
     (phase_r == PH_READ2)) |-> (cnt_r == 3'd0))
    else $error("bit count set in a pulse phase");

  a_attn_addr_only: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_ADDR) |-> !attn_r)
    else $error("attention flag kept outside address wait");

  a_phase_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
    !pop_o |=> $stable(phase_r))
    else $error("phase moved without a sample");
`endif

endmodule

`default_nettype wire
